// ===== rtl/core/qmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmm_pkg
// Shared widths, limits, codes and the configuration record of the quad
// motor mixer.
// ----------------------------------------------------------------------------
package qmm_pkg;

	localparam int TW    = 24;
	localparam int XW    = 27;
	localparam int QW    = 16;
	localparam int DVD_W = 40;
	localparam int DVS_W = 28;

	localparam logic signed [XW-1:0] LOW_LIM  = 27'sd50944;
	localparam logic signed [XW-1:0] HIGH_LIM = 27'sd511744;
	localparam logic [14:0]          W_MIN    = 15'd13107;
	localparam logic [14:0]          W_MAX    = 15'd19661;
	localparam logic [10:0]          CNT_MAX  = 11'd1999;

	typedef enum logic [2:0] {
		MODE_PLAIN  = 3'd0,
		MODE_THR_DN = 3'd1,
		MODE_ATT_DN = 3'd2,
		MODE_THR_UP = 3'd3,
		MODE_ATT_UP = 3'd4,
		MODE_BOTH   = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		REG_THR_GAIN = 3'd0,
		REG_THR_OFF  = 3'd1,
		REG_ROLL_GAIN = 3'd2,
		REG_ROLL_OFF = 3'd3,
		REG_PITCH_GAIN = 3'd4,
		REG_PITCH_OFF = 3'd5,
		REG_YAW_GAIN = 3'd6,
		REG_YAW_OFF  = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [11:0]        thr_gain;
		logic signed [11:0] thr_off;
		logic [11:0]        roll_gain;
		logic signed [11:0] roll_off;
		logic [11:0]        pitch_gain;
		logic signed [11:0] pitch_off;
		logic [11:0]        yaw_gain;
		logic signed [11:0] yaw_off;
	} cfg_t;

endpackage
`default_nettype wire

// ===== rtl/core/qmm_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmm_regs
// Register bank for gains and offsets behind a simple APB slave.
// ----------------------------------------------------------------------------
module qmm_regs (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	output qmm_pkg::cfg_t  cfg
);
	import qmm_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_gain   <= 12'd2000;
			cfg_q.thr_off    <= -12'sd160;
			cfg_q.roll_gain  <= 12'd1000;
			cfg_q.roll_off   <= 12'sd0;
			cfg_q.pitch_gain <= 12'd1000;
			cfg_q.pitch_off  <= 12'sd0;
			cfg_q.yaw_gain   <= 12'd1000;
			cfg_q.yaw_off    <= 12'sd0;
		end else if (wr) begin
			case (idx)
				REG_THR_GAIN:   cfg_q.thr_gain   <= pwdata[11:0];
				REG_THR_OFF:    cfg_q.thr_off    <= pwdata[11:0];
				REG_ROLL_GAIN:  cfg_q.roll_gain  <= pwdata[11:0];
				REG_ROLL_OFF:   cfg_q.roll_off   <= pwdata[11:0];
				REG_PITCH_GAIN: cfg_q.pitch_gain <= pwdata[11:0];
				REG_PITCH_OFF:  cfg_q.pitch_off  <= pwdata[11:0];
				REG_YAW_GAIN:   cfg_q.yaw_gain   <= pwdata[11:0];
				REG_YAW_OFF:    cfg_q.yaw_off    <= pwdata[11:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_THR_GAIN:   prdata = {20'd0, cfg_q.thr_gain};
			REG_THR_OFF:    prdata = {20'd0, cfg_q.thr_off};
			REG_ROLL_GAIN:  prdata = {20'd0, cfg_q.roll_gain};
			REG_ROLL_OFF:   prdata = {20'd0, cfg_q.roll_off};
			REG_PITCH_GAIN: prdata = {20'd0, cfg_q.pitch_gain};
			REG_PITCH_OFF:  prdata = {20'd0, cfg_q.pitch_off};
			REG_YAW_GAIN:   prdata = {20'd0, cfg_q.yaw_gain};
			REG_YAW_OFF:    prdata = {20'd0, cfg_q.yaw_off};
			default:        prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/qmm_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmm_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit and a nonzero-remainder flag.
// ----------------------------------------------------------------------------
module qmm_div (
	input  logic                       clk,
	input  logic [qmm_pkg::QW:0]       en,
	input  logic [qmm_pkg::DVD_W-1:0]  dvd,
	input  logic [qmm_pkg::DVS_W-1:0]  dvs,
	output logic [qmm_pkg::QW-1:0]     quo,
	output logic                       rem_nz,
	output logic                       ovf
);
	import qmm_pkg::*;

	logic [DVS_W-1:0] rem_s [QW+1];
	logic [QW-1:0]    lo_s  [QW+1];
	logic [QW-1:0]    quo_s [QW+1];
	logic [DVS_W-1:0] dvs_s [QW+1];
	logic             ovf_s [QW+1];

	// quotient fits only if the high part is below the divisor
	always_ff @(posedge clk) begin
		if (en[0]) begin
			ovf_s[0] <= DVS_W'(dvd[DVD_W-1:QW]) >= dvs;
			rem_s[0] <= DVS_W'(dvd[DVD_W-1:QW]);
			lo_s[0]  <= dvd[QW-1:0];
			quo_s[0] <= '0;
			dvs_s[0] <= dvs;
		end
	end

	for (genvar i = 1; i <= QW; i++) begin : g_step
		logic [DVS_W:0] trial;
		logic [DVS_W:0] diff;
		logic           ge;

		assign trial = {rem_s[i-1], lo_s[i-1][QW-1]};
		assign diff  = trial - {1'b0, dvs_s[i-1]};
		assign ge    = trial >= {1'b0, dvs_s[i-1]};

		always_ff @(posedge clk) begin
			if (en[i]) begin
				rem_s[i] <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
				lo_s[i]  <= {lo_s[i-1][QW-2:0], 1'b0};
				quo_s[i] <= {quo_s[i-1][QW-2:0], ge};
				dvs_s[i] <= dvs_s[i-1];
				ovf_s[i] <= ovf_s[i-1];
			end
		end
	end

	assign quo    = quo_s[QW];
	assign rem_nz = |rem_s[QW];
	assign ovf    = ovf_s[QW];

endmodule
`default_nettype wire

// ===== rtl/core/quad_motor_mixer_desaturate.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quad_motor_mixer_desaturate
// X-quad motor mixer with throttle and attitude desaturation.
// ----------------------------------------------------------------------------
// Takes one item per clock while the output is not stalled and returns its
// four motor commands from the last stage register. The depth is set by the two 16-bit
// quotient pipelines (throttle weight and attitude scale, 17 stages each)
// that run side by side, plus five stages of scaling and mixing in front and
// four of weighting and final mixing behind. Stalls collapse bubbles, so an
// item is taken whenever some stage ahead of it is empty.
module quad_motor_mixer_desaturate (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               att_valid,
	output logic               att_stall,
	input  logic [15:0]        throttle_frac,
	input  logic signed [15:0] roll_norm,
	input  logic signed [15:0] pitch_norm,
	input  logic signed [15:0] yaw_norm,
	output logic               mot_valid,
	input  logic               mot_stall,
	output logic [10:0]        motor_a,
	output logic [10:0]        motor_b,
	output logic [10:0]        motor_c,
	output logic [10:0]        motor_d,
	output logic [3:0]         low_flags,
	output logic [3:0]         high_flags,
	output logic [2:0]         mix_mode
);
	import qmm_pkg::*;

	localparam int K_DIV = 5;
	localparam int K_P1  = K_DIV + QW + 1;
	localparam int NST   = K_P1 + 4;

	typedef enum logic [2:0] {
		CLS_IDLE,
		CLS_PLAIN,
		CLS_HI,
		CLS_LO,
		CLS_BOTH
	} cls_t;

	typedef struct packed {
		logic signed [TW-1:0] t;
		logic signed [TW-1:0] r;
		logic signed [TW-1:0] p;
		logic signed [TW-1:0] y;
		logic signed [TW-1:0] wt;
		logic [3:0]           low;
		logic [3:0]           high;
		cls_t                 cls;
		logic                 wneg;
		logic                 szero;
		logic                 sneg;
	} side_t;

	function automatic logic signed [TW-1:0] off_q8(input logic signed [11:0] o);
		return {{(TW-20){o[11]}}, o, 8'h00};
	endfunction

	function automatic logic [10:0] to_cnt(input logic signed [XW-1:0] v);
		logic [XW-9:0] c;
		c = v[XW-1:8];
		if (v <= 0)
			return 11'd0;
		else if (c > (XW-8)'(CNT_MAX))
			return CNT_MAX;
		else
			return c[10:0];
	endfunction

	cfg_t cfg;

	qmm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// stage flow control
	logic [NST-1:0] vld_q;
	logic [NST-1:0] vld_nxt;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = !vld_q[NST-1] || !mot_stall;
		for (int k = NST - 2; k >= 0; k--)
			en[k] = !vld_q[k] || en[k+1];
	end

	assign vld_nxt   = {vld_q[NST-2:0], att_valid};
	assign att_stall = !en[0];
	assign mot_valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NST; k++)
				if (en[k])
					vld_q[k] <= vld_nxt[k];
		end
	end

	// stage 1: gain products
	logic [27:0]        pt_s1;
	logic signed [28:0] pr_s1, pp_s1, py_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pt_s1 <= 28'(cfg.thr_gain) * 28'(throttle_frac);
			pr_s1 <= $signed({1'b0, cfg.roll_gain}) * roll_norm;
			pp_s1 <= $signed({1'b0, cfg.pitch_gain}) * pitch_norm;
			py_s1 <= $signed({1'b0, cfg.yaw_gain}) * yaw_norm;
		end
	end

	// stage 2: scaled terms in q8 counts
	logic signed [TW-1:0] t_s2, r_s2, p_s2, y_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			t_s2 <= $signed({3'b000, pt_s1[27:7]}) + off_q8(cfg.thr_off);
			r_s2 <= TW'(pr_s1 >>> 7) + off_q8(cfg.roll_off);
			p_s2 <= TW'(pp_s1 >>> 7) + off_q8(cfg.pitch_off);
			y_s2 <= TW'(py_s1 >>> 7) + off_q8(cfg.yaw_off);
		end
	end

	// stage 3: plain mix and limit weight products
	logic signed [TW-1:0] m_s3 [4];
	logic signed [TW-1:0] t_s3, r_s3, p_s3, y_s3;
	logic signed [TW+14:0] whi_s3, wlo_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			m_s3[0] <= t_s2 - r_s2 + p_s2 + y_s2;
			m_s3[1] <= t_s2 - r_s2 - p_s2 - y_s2;
			m_s3[2] <= t_s2 + r_s2 + p_s2 - y_s2;
			m_s3[3] <= t_s2 + r_s2 - p_s2 + y_s2;
			t_s3    <= t_s2;
			r_s3    <= r_s2;
			p_s3    <= p_s2;
			y_s3    <= y_s2;
			whi_s3  <= t_s2 * $signed({1'b0, W_MIN});
			wlo_s3  <= t_s2 * $signed({1'b0, W_MAX});
		end
	end

	// stage 4: flags, side class, extreme motor
	logic [3:0]           lo4, hi4;
	logic                 idle4;
	cls_t                 cls4;
	logic signed [TW-1:0] mx4, mn4;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			lo4[i] = m_s3[i] <= LOW_LIM;
			hi4[i] = !lo4[i] && (m_s3[i] >= HIGH_LIM);
		end
		idle4 = t_s3 <= LOW_LIM;
		if (idle4)
			cls4 = CLS_IDLE;
		else if ((|hi4) && !(|lo4))
			cls4 = CLS_HI;
		else if ((|lo4) && !(|hi4))
			cls4 = CLS_LO;
		else if ((|lo4) && (|hi4))
			cls4 = CLS_BOTH;
		else
			cls4 = CLS_PLAIN;
		mx4 = m_s3[0];
		mn4 = m_s3[0];
		for (int i = 1; i < 4; i++) begin
			if (m_s3[i] > mx4)
				mx4 = m_s3[i];
			if (m_s3[i] < mn4)
				mn4 = m_s3[i];
		end
	end

	logic signed [TW-1:0] t_s4, r_s4, p_s4, y_s4, ext_s4, wt_s4;
	logic [3:0]           low_s4, high_s4;
	cls_t                 cls_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			t_s4    <= t_s3;
			r_s4    <= r_s3;
			p_s4    <= p_s3;
			y_s4    <= y_s3;
			low_s4  <= idle4 ? 4'd0 : lo4;
			high_s4 <= idle4 ? 4'd0 : hi4;
			cls_s4  <= cls4;
			ext_s4  <= (cls4 == CLS_LO) ? mn4 : mx4;
			wt_s4   <= (cls4 == CLS_LO) ? TW'(wlo_s3 >>> 14) : TW'(whi_s3 >>> 14);
		end
	end

	// stage 5: divider operands in sign and magnitude
	logic signed [XW-1:0] lim5, nw5, num5, den5;
	logic [XW-1:0]        an5, dn5;
	logic                 wneg5, szero5, sneg5;

	always_comb begin
		lim5   = (cls_s4 == CLS_LO) ? LOW_LIM : HIGH_LIM;
		nw5    = lim5 - XW'(ext_s4) + XW'(t_s4);
		num5   = lim5 - XW'(wt_s4);
		den5   = XW'(ext_s4) - XW'(t_s4);
		wneg5  = nw5 <= 0;
		sneg5  = num5[XW-1] ^ den5[XW-1];
		szero5 = (den5 == 0) || ((cls_s4 == CLS_HI) && den5[XW-1]);
		an5    = num5[XW-1] ? XW'(-num5) : XW'(num5);
		dn5    = den5[XW-1] ? XW'(-den5) : XW'(den5);
	end

	logic [DVD_W-1:0] dvdw_s5, dvds_s5;
	logic [DVS_W-1:0] dvsw_s5, dvss_s5;
	side_t            side_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			dvdw_s5       <= wneg5 ? '0 : {nw5[DVD_W-15:0], 14'd0};
			dvsw_s5       <= {{(DVS_W-TW){1'b0}}, t_s4};
			dvds_s5       <= {an5[DVD_W-15:0], 14'd0};
			dvss_s5       <= DVS_W'(dn5);
			side_s5.t     <= t_s4;
			side_s5.r     <= r_s4;
			side_s5.p     <= p_s4;
			side_s5.y     <= y_s4;
			side_s5.wt    <= wt_s4;
			side_s5.low   <= low_s4;
			side_s5.high  <= high_s4;
			side_s5.cls   <= cls_s4;
			side_s5.wneg  <= wneg5;
			side_s5.szero <= szero5;
			side_s5.sneg  <= sneg5;
		end
	end

	// quotient pipelines
	logic [QW-1:0] quow, quos;
	logic          ovfw, ovfs, rnzs;

	qmm_div u_div_w (
		.clk    (clk),
		.en     (en[K_DIV+QW:K_DIV]),
		.dvd    (dvdw_s5),
		.dvs    (dvsw_s5),
		.quo    (quow),
		.rem_nz (),
		.ovf    (ovfw)
	);

	qmm_div u_div_s (
		.clk    (clk),
		.en     (en[K_DIV+QW:K_DIV]),
		.dvd    (dvds_s5),
		.dvs    (dvss_s5),
		.quo    (quos),
		.rem_nz (rnzs),
		.ovf    (ovfs)
	);

	side_t side_sd [QW+1];

	always_ff @(posedge clk) begin
		if (en[K_DIV])
			side_sd[0] <= side_s5;
		for (int j = 1; j <= QW; j++)
			if (en[K_DIV+j])
				side_sd[j] <= side_sd[j-1];
	end

	// stage 23: weight, scale and mode
	side_t                side23;
	mode_t                mode23;
	logic [QW:0]          mag23;
	logic signed [QW:0]   s23;

	assign side23 = side_sd[QW];

	always_comb begin
		case (side23.cls)
			CLS_HI:
				mode23 = (!side23.wneg && (ovfw || quow >= QW'(W_MIN))) ?
					MODE_THR_DN : MODE_ATT_DN;
			CLS_LO:
				mode23 = (!ovfw && quow <= QW'(W_MAX)) ? MODE_THR_UP : MODE_ATT_UP;
			CLS_BOTH:
				mode23 = MODE_BOTH;
			default:
				mode23 = MODE_PLAIN;
		endcase
		mag23 = {1'b0, quos} + (QW+1)'(rnzs);
		if (side23.szero)
			s23 = '0;
		else if (!side23.sneg)
			s23 = (ovfs || quos[QW-1]) ? $signed({2'b00, {(QW-1){1'b1}}}) :
				$signed({1'b0, quos});
		else if (ovfs || mag23 > {2'b01, {(QW-1){1'b0}}})
			s23 = $signed({2'b11, {(QW-1){1'b0}}});
		else
			s23 = -$signed(mag23);
	end

	side_t              side_s23;
	mode_t              mode_s23;
	logic [QW-1:0]      w_s23;
	logic signed [QW:0] s_s23;

	always_ff @(posedge clk) begin
		if (en[K_P1]) begin
			side_s23 <= side23;
			mode_s23 <= mode23;
			w_s23    <= quow;
			s_s23    <= s23;
		end
	end

	// stage 24: weighted throttle and scaled attitude products
	logic signed [TW+QW:0] tt_s24, rs_s24, ps_s24, ys_s24;
	side_t                 side_s24;
	mode_t                 mode_s24;

	always_ff @(posedge clk) begin
		if (en[K_P1+1]) begin
			tt_s24   <= $signed({1'b0, w_s23}) * side_s23.t;
			rs_s24   <= side_s23.r * s_s23;
			ps_s24   <= side_s23.p * s_s23;
			ys_s24   <= side_s23.y * s_s23;
			side_s24 <= side_s23;
			mode_s24 <= mode_s23;
		end
	end

	// stage 25: pick mix operands
	logic signed [XW-1:0] tc25, rc25, pc25, yc25;

	always_comb begin
		case (mode_s24)
			MODE_THR_DN, MODE_THR_UP: begin
				tc25 = XW'(tt_s24 >>> 14);
				rc25 = XW'(side_s24.r);
				pc25 = XW'(side_s24.p);
				yc25 = XW'(side_s24.y);
			end
			MODE_ATT_DN, MODE_ATT_UP: begin
				tc25 = XW'(side_s24.wt);
				rc25 = XW'(rs_s24 >>> 14);
				pc25 = XW'(ps_s24 >>> 14);
				yc25 = XW'(ys_s24 >>> 14);
			end
			default: begin
				tc25 = XW'(side_s24.t);
				rc25 = XW'(side_s24.r);
				pc25 = XW'(side_s24.p);
				yc25 = XW'(side_s24.y);
			end
		endcase
		if (side_s24.cls == CLS_IDLE) begin
			tc25 = '0;
			rc25 = '0;
			pc25 = '0;
			yc25 = '0;
		end
	end

	logic signed [XW-1:0] tc_s25, rc_s25, pc_s25, yc_s25;
	logic [3:0]           low_s25, high_s25;
	mode_t                mode_s25;

	always_ff @(posedge clk) begin
		if (en[K_P1+2]) begin
			tc_s25   <= tc25;
			rc_s25   <= rc25;
			pc_s25   <= pc25;
			yc_s25   <= yc25;
			low_s25  <= side_s24.low;
			high_s25 <= side_s24.high;
			mode_s25 <= mode_s24;
		end
	end

	// stage 26: final mix and clamp into the output register
	logic [10:0] mcnt_s26 [4];
	logic [3:0]  low_s26, high_s26;
	mode_t       mode_s26;

	always_ff @(posedge clk) begin
		if (en[K_P1+3]) begin
			mcnt_s26[0] <= to_cnt(tc_s25 - rc_s25 + pc_s25 + yc_s25);
			mcnt_s26[1] <= to_cnt(tc_s25 - rc_s25 - pc_s25 - yc_s25);
			mcnt_s26[2] <= to_cnt(tc_s25 + rc_s25 + pc_s25 - yc_s25);
			mcnt_s26[3] <= to_cnt(tc_s25 + rc_s25 - pc_s25 + yc_s25);
			low_s26     <= low_s25;
			high_s26    <= high_s25;
			mode_s26    <= mode_s25;
		end
	end

	assign motor_a    = mcnt_s26[0];
	assign motor_b    = mcnt_s26[1];
	assign motor_c    = mcnt_s26[2];
	assign motor_d    = mcnt_s26[3];
	assign low_flags  = low_s26;
	assign high_flags = high_s26;
	assign mix_mode   = mode_s26;

endmodule
`default_nettype wire

// ===== rtl/core/qmm_chk.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qmm_chk
// Port-level checks on the mixer output channel, bound to the top level.
// ----------------------------------------------------------------------------
module qmm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        mot_valid,
	input logic        mot_stall,
	input logic [10:0] motor_a,
	input logic [10:0] motor_b,
	input logic [10:0] motor_c,
	input logic [10:0] motor_d,
	input logic [3:0]  low_flags,
	input logic [3:0]  high_flags,
	input logic [2:0]  mix_mode
);
	import qmm_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mot_valid && mot_stall |=> mot_valid)
		else $error("item dropped while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		mot_valid |-> motor_a <= CNT_MAX && motor_b <= CNT_MAX &&
			motor_c <= CNT_MAX && motor_d <= CNT_MAX)
		else $error("motor command above limit");

	a_plain: assert property (@(posedge clk) disable iff (!arst_n)
		mot_valid && mix_mode == MODE_PLAIN |-> low_flags == 4'd0 && high_flags == 4'd0)
		else $error("plain mix with saturation flags");

	a_down: assert property (@(posedge clk) disable iff (!arst_n)
		mot_valid && (mix_mode == MODE_THR_DN || mix_mode == MODE_ATT_DN)
		|-> high_flags != 4'd0 && low_flags == 4'd0)
		else $error("high-side correction without high flags only");

	a_up: assert property (@(posedge clk) disable iff (!arst_n)
		mot_valid && (mix_mode == MODE_THR_UP || mix_mode == MODE_ATT_UP)
		|-> low_flags != 4'd0 && high_flags == 4'd0)
		else $error("low-side correction without low flags only");

endmodule

bind quad_motor_mixer_desaturate qmm_chk u_qmm_chk (.*);
`default_nettype wire
